// ===== hw/rtl/kcl_pkg.sv =====
// shared constants and decode functions for the keypad code lock
`default_nettype none
package kcl_pkg;

  localparam int unsigned DigitW = 4;
  localparam int unsigned SegW   = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [DigitW-1:0] DASH_CODE    = 4'd11;
  localparam logic [SegW-1:0]   H_PATTERN    = 8'h89;
  localparam logic [SegW-1:0]   DASH_PATTERN = 8'hbf;
  localparam logic [CountW-1:0] COUNT_MAX    = 8'hff;

  // register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_CODE_FIRST  = 3'd0;
  localparam logic [2:0] REG_CODE_SECOND = 3'd1;
  localparam logic [2:0] REG_CODE_THIRD  = 3'd2;
  localparam logic [2:0] REG_CODE_FOURTH = 3'd3;
  localparam logic [2:0] REG_TIMEOUT     = 3'd4;

  localparam logic [DigitW-1:0] RST_CODE_FIRST  = 4'd1;
  localparam logic [DigitW-1:0] RST_CODE_SECOND = 4'd2;
  localparam logic [DigitW-1:0] RST_CODE_THIRD  = 4'd3;
  localparam logic [DigitW-1:0] RST_CODE_FOURTH = 4'd4;
  localparam logic [CountW-1:0] RST_TIMEOUT     = 8'd30;

  // common-anode, active-low segment patterns
  function automatic logic [SegW-1:0] seg_decode(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] pat;
    case (digit)
      4'd0:    pat = 8'hc0;
      4'd1:    pat = 8'hf9;
      4'd2:    pat = 8'ha4;
      4'd3:    pat = 8'hb0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hf8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      4'd10:   pat = 8'h7f;
      4'd11:   pat = DASH_PATTERN;
      4'd12:   pat = 8'ha3;
      4'd13:   pat = H_PATTERN;
      default: pat = 8'hff;
    endcase
    return pat;
  endfunction

  // key code from column and row index (both zero based)
  function automatic logic [DigitW-1:0] key_lookup(input logic [1:0] col,
                                                   input logic [1:0] row);
    logic [DigitW-1:0] key;
    case ({col, row})
      4'b00_00: key = 4'd1;
      4'b00_01: key = 4'd4;
      4'b00_10: key = 4'd7;
      4'b00_11: key = 4'd11;
      4'b01_00: key = 4'd2;
      4'b01_01: key = 4'd5;
      4'b01_10: key = 4'd8;
      4'b01_11: key = 4'd0;
      4'b10_00: key = 4'd3;
      4'b10_01: key = 4'd6;
      4'b10_10: key = 4'd9;
      4'b10_11: key = 4'd12;
      default:  key = 4'd0;
    endcase
    return key;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/keypad_code_lock_top.sv =====
// keypad code lock: key encode, entry shift, code compare, pass count and display decode
`default_nettype none
//
// channel   direction  handshake                       payload
// in        input      in_valid_i / in_stall_o         column_low_i, row_low_i
// out       output     out_valid_o / out_stall_i       seg_*_o, key_beep_o, unlock_o,
//                                                      entry_timeout_o
// cfg       input      psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//
// one word per cycle unless a stall holds the output: the whole pass (encode, shift,
// compare, count, decode) is one level of logic from the state and input word into the
// result register; out_valid_o rises in the cycle after acceptance
// in_stall_o is raised only while a result waits in the output register and
// out_stall_i is high; a result taken in the same cycle frees the slot
// reset puts dashes in the entry, clears last key and the mismatch counter,
// and loads the default code 1-2-3-4 with a limit of 30 passes
module keypad_code_lock_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // scan pass word
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [2:0]                column_low_i,
  input  wire logic [3:0]                row_low_i,
  // result word
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [kcl_pkg::SegW-1:0]       seg_first_o,
  output logic [kcl_pkg::SegW-1:0]       seg_second_o,
  output logic [kcl_pkg::SegW-1:0]       seg_third_o,
  output logic [kcl_pkg::SegW-1:0]       seg_fourth_o,
  output logic                           key_beep_o,
  output logic                           unlock_o,
  output logic                           entry_timeout_o,
  // configuration
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [kcl_pkg::AddrW-1:0] paddr,
  input  wire logic [kcl_pkg::DataW-1:0] pwdata,
  output logic [kcl_pkg::DataW-1:0]      prdata,
  output logic                           pready
);
  import kcl_pkg::*;

  // configuration registers
  logic [DigitW-1:0] code_q [4];
  logic [CountW-1:0] timeout_q;

  // lock state
  logic [DigitW-1:0] entry_q [4];
  logic [DigitW-1:0] entry_d [4];
  logic [DigitW-1:0] last_key_q, last_key_d;
  logic [CountW-1:0] count_q, count_d;

  // result register
  logic              out_valid_q;
  logic [SegW-1:0]   seg_q [4];
  logic [SegW-1:0]   seg_d [4];
  logic              beep_q, beep_d;
  logic              unlock_q, unlock_d;
  logic              tmo_q, tmo_d;

  logic              accept;
  logic              cfg_write;
  logic [2:0]        reg_idx;

  // working values of one pass
  logic [1:0]        col_idx;
  logic [1:0]        row_idx;
  logic [DigitW-1:0] key_now;
  logic [DigitW-1:0] shifted [4];
  logic              match;
  logic [CountW-1:0] count_mid;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[AddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // output slot frees when empty or taken this cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // configuration write and read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q[0] <= RST_CODE_FIRST;
      code_q[1] <= RST_CODE_SECOND;
      code_q[2] <= RST_CODE_THIRD;
      code_q[3] <= RST_CODE_FOURTH;
      timeout_q <= RST_TIMEOUT;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_CODE_FIRST:  code_q[0] <= pwdata[DigitW-1:0];
        REG_CODE_SECOND: code_q[1] <= pwdata[DigitW-1:0];
        REG_CODE_THIRD:  code_q[2] <= pwdata[DigitW-1:0];
        REG_CODE_FOURTH: code_q[3] <= pwdata[DigitW-1:0];
        REG_TIMEOUT:     timeout_q <= pwdata[CountW-1:0];
        default: ;  // unmapped slots are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CODE_FIRST:  prdata = {{(DataW-DigitW){1'b0}}, code_q[0]};
      REG_CODE_SECOND: prdata = {{(DataW-DigitW){1'b0}}, code_q[1]};
      REG_CODE_THIRD:  prdata = {{(DataW-DigitW){1'b0}}, code_q[2]};
      REG_CODE_FOURTH: prdata = {{(DataW-DigitW){1'b0}}, code_q[3]};
      REG_TIMEOUT:     prdata = {{(DataW-CountW){1'b0}}, timeout_q};
      default:         prdata = '0;
    endcase
  end

  // priority encoders: lowest low column and row win
  always_comb begin
    if (column_low_i[0])      col_idx = 2'd0;
    else if (column_low_i[1]) col_idx = 2'd1;
    else                      col_idx = 2'd2;
    if (row_low_i[0])         row_idx = 2'd0;
    else if (row_low_i[1])    row_idx = 2'd1;
    else if (row_low_i[2])    row_idx = 2'd2;
    else                      row_idx = 2'd3;
  end

  assign key_now = key_lookup(col_idx, row_idx);

  always_comb begin
    // a column with no row repeats the last key
    last_key_d = last_key_q;
    if (column_low_i != 3'd0 && row_low_i != 4'd0) begin
      last_key_d = key_now;
    end

    // entry shifts left, newest digit on the right
    shifted = entry_q;
    beep_d  = 1'b0;
    if (column_low_i != 3'd0) begin
      shifted[0] = entry_q[1];
      shifted[1] = entry_q[2];
      shifted[2] = entry_q[3];
      shifted[3] = last_key_d;
      beep_d     = 1'b1;
    end

    match = (shifted[0] == code_q[0]) && (shifted[1] == code_q[1]) &&
            (shifted[2] == code_q[2]) && (shifted[3] == code_q[3]);

    // counter holds on a match, otherwise counts up and saturates
    count_mid = count_q;
    if (!match && count_q != COUNT_MAX) begin
      count_mid = count_q + 1'b1;
    end

    // limit check also runs on a matching pass
    tmo_d    = (count_mid >= timeout_q);
    unlock_d = match;
    count_d  = tmo_d ? '0 : count_mid;

    for (int i = 0; i < 4; i++) begin
      entry_d[i] = (match || tmo_d) ? DASH_CODE : shifted[i];
      if (match)      seg_d[i] = H_PATTERN;
      else if (tmo_d) seg_d[i] = DASH_PATTERN;
      else            seg_d[i] = seg_decode(shifted[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        entry_q[i] <= DASH_CODE;
      end
      last_key_q <= '0;
      count_q    <= '0;
    end else if (accept) begin
      entry_q    <= entry_d;
      last_key_q <= last_key_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded only with a new word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seg_q    <= seg_d;
      beep_q   <= beep_d;
      unlock_q <= unlock_d;
      tmo_q    <= tmo_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign seg_first_o     = seg_q[0];
  assign seg_second_o    = seg_q[1];
  assign seg_third_o     = seg_q[2];
  assign seg_fourth_o    = seg_q[3];
  assign key_beep_o      = beep_q;
  assign unlock_o        = unlock_q;
  assign entry_timeout_o = tmo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/kcl_checker.sv =====
// port-level checker for the keypad code lock, bound to the top level
`default_nettype none
module kcl_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [kcl_pkg::SegW-1:0]  seg_first_o,
  input wire logic [kcl_pkg::SegW-1:0]  seg_second_o,
  input wire logic [kcl_pkg::SegW-1:0]  seg_third_o,
  input wire logic [kcl_pkg::SegW-1:0]  seg_fourth_o,
  input wire logic                      unlock_o,
  input wire logic                      entry_timeout_o
);
  import kcl_pkg::*;

  // an accepted word always shows up the next cycle
  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word did not reach the output");

  // unlock shows H on every digit
  a_unlock_h: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unlock_o) |->
      (seg_first_o == H_PATTERN && seg_second_o == H_PATTERN &&
       seg_third_o == H_PATTERN && seg_fourth_o == H_PATTERN))
    else $error("unlock without H pattern");

  // a timeout without unlock shows dashes
  a_timeout_dash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_timeout_o && !unlock_o) |->
      (seg_first_o == DASH_PATTERN && seg_second_o == DASH_PATTERN &&
       seg_third_o == DASH_PATTERN && seg_fourth_o == DASH_PATTERN))
    else $error("timeout without dash pattern");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(seg_first_o) && $stable(unlock_o)))
    else $error("stalled result changed");

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the keypad code lock: directed and random scan passes
`timescale 1ns / 1ps

module tb;
  import kcl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // key codes with no digit value
  localparam logic [DigitW-1:0] KEY_STAR = DASH_CODE;
  localparam logic [DigitW-1:0] KEY_HASH = 4'd12;
  // a digit that no key produces, so a code holding it never opens
  localparam logic [DigitW-1:0] KEY_NONE = 4'd10;

  // register index with nothing behind it
  localparam logic [2:0] REG_UNUSED = 3'd5;

  // key code by (column * 4 + row), element 0 on the right
  localparam logic [11:0][DigitW-1:0] KEY_MAP = {
    4'd12, 4'd9, 4'd6, 4'd3,
    4'd0,  4'd8, 4'd5, 4'd2,
    4'd11, 4'd7, 4'd4, 4'd1
  };

  // active-low display patterns by digit, element 0 on the right
  localparam logic [15:0][SegW-1:0] SEG_MAP = {
    8'hff, 8'hff, 8'h89, 8'ha3, 8'hbf, 8'h7f, 8'h90, 8'h80,
    8'hf8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
  };

  // one display word as the lock shows it after a pass
  typedef struct packed {
    logic [3:0][SegW-1:0] seg;
    logic                 beep;
    logic                 unlock;
    logic                 timeout;
  } lock_result_t;

  // tracks the lock state and the display words still owed by the block
  class lock_scoreboard;
    logic [3:0][DigitW-1:0] code;
    logic [CountW-1:0]      limit;
    logic [3:0][DigitW-1:0] entry;
    logic [DigitW-1:0]      last_key;
    logic [CountW-1:0]      miss_count;
    lock_result_t           owed_displays[$];
    int                     errors;

    function new();
      code       = {RST_CODE_FOURTH, RST_CODE_THIRD, RST_CODE_SECOND, RST_CODE_FIRST};
      limit      = RST_TIMEOUT;
      entry      = {4{DASH_CODE}};
      last_key   = '0;
      miss_count = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [DataW-1:0] value);
      case (idx)
        REG_CODE_FIRST:  code[0] = value[3:0];
        REG_CODE_SECOND: code[1] = value[3:0];
        REG_CODE_THIRD:  code[2] = value[3:0];
        REG_CODE_FOURTH: code[3] = value[3:0];
        REG_TIMEOUT:     limit   = value[7:0];
        default: ;
      endcase
    endfunction

    // one accepted scan pass: advance the lock and owe its display word
    function void note_pass(logic [2:0] col, logic [3:0] row);
      lock_result_t want;
      int           c;
      int           r;
      want = '0;
      if (col != 3'b000) begin
        c = col[0] ? 0 : (col[1] ? 1 : 2);
        if (row != 4'b0000) begin
          r = row[0] ? 0 : (row[1] ? 1 : (row[2] ? 2 : 3));
          last_key = KEY_MAP[c*4 + r];
        end
        entry     = {last_key, entry[3], entry[2], entry[1]};
        want.beep = 1'b1;
      end
      for (int i = 0; i < 4; i++) want.seg[i] = SEG_MAP[entry[i]];
      if (entry == code) begin
        want.unlock = 1'b1;
        entry       = {4{DASH_CODE}};
      end else if (miss_count != COUNT_MAX) begin
        miss_count++;
      end
      if (miss_count >= limit) begin
        miss_count   = '0;
        entry        = {4{DASH_CODE}};
        want.timeout = 1'b1;
        want.seg     = {4{DASH_PATTERN}};
      end
      if (want.unlock) want.seg = {4{H_PATTERN}};
      owed_displays.push_back(want);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(lock_result_t got);
      lock_result_t want;
      if (owed_displays.size() == 0) begin
        $error("display word with no scan pass outstanding");
        errors++;
        return;
      end
      want = owed_displays.pop_front();
      compare("seg_first", want.seg[0], got.seg[0]);
      compare("seg_second", want.seg[1], got.seg[1]);
      compare("seg_third", want.seg[2], got.seg[2]);
      compare("seg_fourth", want.seg[3], got.seg[3]);
      compare("key_beep", want.beep, got.beep);
      compare("unlock", want.unlock, got.unlock);
      compare("entry_timeout", want.timeout, got.timeout);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        column_low_i;
  logic [3:0]        row_low_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [SegW-1:0]   seg_first_o;
  logic [SegW-1:0]   seg_second_o;
  logic [SegW-1:0]   seg_third_o;
  logic [SegW-1:0]   seg_fourth_o;
  logic              key_beep_o;
  logic              unlock_o;
  logic              entry_timeout_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  keypad_code_lock_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .column_low_i   (column_low_i),
    .row_low_i      (row_low_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .seg_first_o    (seg_first_o),
    .seg_second_o   (seg_second_o),
    .seg_third_o    (seg_third_o),
    .seg_fourth_o   (seg_fourth_o),
    .key_beep_o     (key_beep_o),
    .unlock_o       (unlock_o),
    .entry_timeout_o(entry_timeout_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  lock_scoreboard lock_sb = new();

  // idle odds out of a hundred, changed per phase
  int                send_idle_pct = 0;
  int                stall_pct     = 0;
  int                passes_sent   = 0;
  int                cycle_count   = 0;
  // code currently programmed, used to type well-formed entries
  logic [DigitW-1:0] lock_code [4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("== FAIL ==");
    $finish;
  end

  // result side: stall changes on the falling edge, words are taken on the rising edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        lock_sb.check_result({seg_fourth_o, seg_third_o, seg_second_o, seg_first_o,
                              key_beep_o, unlock_o, entry_timeout_o});
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // register write: setup then access; entered and left on a falling edge
  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lock_sb.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  // program code and pass limit; junk in the unused upper bits must be dropped
  task automatic program_lock(input logic [DigitW-1:0] d0, input logic [DigitW-1:0] d1,
                              input logic [DigitW-1:0] d2, input logic [DigitW-1:0] d3,
                              input logic [CountW-1:0] passes);
    logic [DataW-1:0] junk;
    junk = $urandom;
    write_reg(REG_CODE_FIRST, {junk[31:4], d0});
    write_reg(REG_CODE_SECOND, {junk[31:4], d1});
    write_reg(REG_CODE_THIRD, {junk[31:4], d2});
    write_reg(REG_CODE_FOURTH, {junk[31:4], d3});
    write_reg(REG_TIMEOUT, {junk[31:8], passes});
    lock_code = '{d0, d1, d2, d3};
  endtask

  // offer one scan pass and hold it until taken; ends on the falling edge after
  task automatic send_pass(input logic [2:0] col, input logic [3:0] row);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    column_low_i <= col;
    row_low_i    <= row;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      if (!taken) @(negedge clk_i);
    end
    lock_sb.note_pass(col, row);
    passes_sent++;
    @(negedge clk_i);
  endtask

  // stop sending until every owed word is back, then let the pipe idle before returning
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (lock_sb.owed_displays.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // press one key; higher column and row bits are set at random to test priority
  task automatic press_key(input logic [DigitW-1:0] key);
    int         idx;
    int         c;
    int         r;
    logic [2:0] col;
    logic [3:0] row;
    idx = -1;
    for (int i = 0; i < 12; i++) if (KEY_MAP[i] == key) idx = i;
    if (idx < 0) idx = $urandom_range(11);
    c   = idx / 4;
    r   = idx % 4;
    col = 3'($urandom);
    col = ((col >> (c + 1)) << (c + 1)) | (3'b001 << c);
    row = 4'($urandom);
    row = ((row >> (r + 1)) << (r + 1)) | (4'b0001 << r);
    // a repeated key may come as a column with no row, which reuses the last key
    if (KEY_MAP[idx] == lock_sb.last_key && $urandom_range(1) == 1) row = 4'b0000;
    send_pass(col, row);
  endtask

  // mostly typed codes, some with a wrong digit, the rest raw scan noise
  task automatic run_phase(input int n_passes, input int noise_pct);
    int start;
    int wrong;
    bit paused;
    start  = passes_sent;
    paused = 1'b0;
    while (passes_sent - start < n_passes) begin
      if (!paused && passes_sent - start >= n_passes / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < noise_pct) begin
        send_pass(3'($urandom), 4'($urandom));
      end else begin
        wrong = ($urandom_range(3) == 0) ? int'($urandom_range(3)) : -1;
        for (int i = 0; i < 4; i++)
          press_key(i == wrong ? 4'($urandom_range(12)) : lock_code[i]);
      end
    end
  endtask

  function automatic logic [DigitW-1:0] any_key();
    return KEY_MAP[$urandom_range(11)];
  endfunction

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    column_low_i = '0;
    row_low_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    lock_code    = '{RST_CODE_FIRST, RST_CODE_SECOND, RST_CODE_THIRD, RST_CODE_FOURTH};

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, default code 1-2-3-4 with a 30 pass limit
    send_pass(3'b000, 4'b0000);  // nothing pressed
    send_pass(3'b001, 4'b0000);  // column only: reuses the reset key
    send_pass(3'b001, 4'b0001);  // 1
    send_pass(3'b010, 4'b0001);  // 2
    send_pass(3'b100, 4'b0001);  // 3
    send_pass(3'b001, 4'b0010);  // 4, opens the lock
    send_pass(3'b010, 4'b0010);  // 5
    send_pass(3'b100, 4'b0010);  // 6
    send_pass(3'b001, 4'b0100);  // 7
    send_pass(3'b010, 4'b0100);  // 8
    send_pass(3'b100, 4'b0100);  // 9
    send_pass(3'b001, 4'b1000);  // star
    send_pass(3'b010, 4'b1000);  // 0
    send_pass(3'b100, 4'b1000);  // hash
    send_pass(3'b111, 4'b1111);  // everything low: lowest column and row win
    send_pass(3'b110, 4'b1110);
    send_pass(3'b100, 4'b1100);
    send_pass(3'b000, 4'b1111);  // rows with no column
    send_pass(3'b110, 4'b0000);
    send_pass(3'b011, 4'b1000);
    send_pass(3'b111, 4'b0000);
    drain();

    // zero limit clears every pass; a match on the same pass shows H with the timeout
    program_lock(KEY_STAR, KEY_STAR, KEY_STAR, KEY_HASH, 8'd0);
    write_reg(REG_UNUSED, 32'hffff_ffff);  // no register here, must change nothing
    send_pass(3'b000, 4'b0000);  // idle pass clears the entry to dashes
    send_pass(3'b100, 4'b1000);  // hash behind three dashes matches
    send_pass(3'b010, 4'b0010);
    drain();

    // unmatchable code with the widest limit: the counter runs all the way up
    program_lock(KEY_NONE, 4'd0, KEY_HASH, 4'd0, 8'd255);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_phase(270, 30);
    drain();

    // limit of one: only a code that fits behind three dashes can open
    program_lock(KEY_STAR, KEY_STAR, KEY_STAR, 4'd0, 8'd1);
    send_idle_pct = 51;
    stall_pct     = 0;
    run_phase(250, 25);
    drain();

    // code at the digit extremes, middling limit, receiver stalling
    program_lock(4'd0, KEY_HASH, KEY_HASH, 4'd0, 8'($urandom_range(4, 40)));
    send_idle_pct = 0;
    stall_pct     = 51;
    run_phase(260, 20);
    drain();

    // any code, default limit, both sides idling
    program_lock(any_key(), any_key(), any_key(), any_key(), RST_TIMEOUT);
    send_idle_pct = 15;
    stall_pct     = 15;
    run_phase(260, 20);
    drain();

    if (lock_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/kcl_pkg.sv
hw/rtl/keypad_code_lock_top.sv
hw/rtl/kcl_checker.sv
tb/tb.sv
